/* hdl/bcle_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package bcle_pkg;

    localparam int DEPTH = 16;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int POS_W = 5;
    localparam int PW    = (CW > POS_W) ? CW : POS_W;
    localparam int DW    = 32;

    typedef enum logic [1:0] {
        OP_INS_FRONT = 2'd0,
        OP_INS_END   = 2'd1,
        OP_DELETE    = 2'd2,
        OP_DISPLAY   = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_FULL   = 2'd2,
        ST_BADPOS = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_DEL_RD,
        S_DEL_WR,
        S_DISP_RD,
        S_DISP_LD,
        S_RESP
    } state_t;

    typedef struct packed {
        logic                 wr_en;
        logic [AW-1:0]        addr;
        logic signed [DW-1:0] wr_data;
    } store_req_t;

    // physical slot of a list position: head plus offset, wrapped once
    function automatic logic [AW-1:0] addr_wrap(input logic [AW-1:0] base,
                                                input logic [CW-1:0] off);
        logic [CW:0] sum;
        sum = (CW + 1)'(base) + (CW + 1)'(off);
        if (sum >= (CW + 1)'(DEPTH))
        begin
            sum = sum - (CW + 1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

endpackage

`default_nettype wire

/* hdl/bcle_cmd_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface bcle_cmd_if import bcle_pkg::*;;
    logic                 valid;
    logic                 ready;
    opcode_t              opcode;
    logic signed [DW-1:0] value;
    logic [POS_W-1:0]     position;

    modport source (output valid, output opcode, output value, output position,
                    input ready);
    modport sink (input valid, input opcode, input value, input position,
                  output ready);
endinterface

`default_nettype wire

/* hdl/bcle_rsp_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface bcle_rsp_if import bcle_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic signed [DW-1:0] data;
    status_t              status;
    logic                 is_last;

    modport source (output valid, output data, output status, output is_last,
                    input ready);
    modport sink (input valid, input data, input status, input is_last,
                  output ready);
endinterface

`default_nettype wire

/* hdl/bcle_store.sv */
`timescale 1ns / 1ps
`default_nettype none

module bcle_store import bcle_pkg::*;
(
    input  wire logic                 clk,
    input  wire store_req_t           req,
    output logic signed [DW-1:0]      rd_data
);

    logic signed [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.addr] <= req.wr_data;
        end
        rd_data <= mem[req.addr];
    end

endmodule

`default_nettype wire

/* hdl/bounded_circular_list_engine.sv */
`timescale 1ns / 1ps
`default_nettype none

// insert: executed in S_EXEC, which also registers the result word that S_RESP then offers
// delete: S_DEL_RD and S_DEL_WR alternate, one read and one write per shifted entry
// display: per entry S_DISP_RD, S_DISP_LD, then S_RESP until taken; one command at a time
// entries live in a circular store; the single slot adder (head + offset) is shared by all steps
// reset clears head, count and the control state; store contents stay undefined, no clearing pass
module bounded_circular_list_engine import bcle_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    bcle_cmd_if.sink  cmd,
    bcle_rsp_if.source rsp
);

    state_t               state_reg, state_next;
    logic [AW-1:0]        head_reg, head_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [CW-1:0]        idx_reg, idx_next;
    opcode_t              op_reg, op_next;
    logic signed [DW-1:0] value_reg, value_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic                 out_valid_reg, out_valid_next;
    logic signed [DW-1:0] out_data_reg, out_data_next;
    status_t              out_status_reg, out_status_next;
    logic                 out_last_reg, out_last_next;

    store_req_t           store_req;
    logic signed [DW-1:0] rd_data;
    logic [CW-1:0]        offset;
    logic [AW-1:0]        slot;
    logic [CW-1:0]        idx_inc;
    logic                 cmd_fire;
    logic                 rsp_fire;
    logic                 full;
    logic                 empty;
    logic                 bad_pos;

    bcle_store u_store (
        .clk     (clk),
        .req     (store_req),
        .rd_data (rd_data)
    );

    assign cmd_fire = cmd.valid && cmd.ready;
    assign rsp_fire = rsp.valid && rsp.ready;
    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign bad_pos  = (pos_reg == '0) || (PW'(pos_reg) > PW'(count_reg));
    assign idx_inc  = idx_reg + CW'(1);
    assign slot     = addr_wrap(head_reg, offset);

    assign cmd.ready   = (state_reg == S_IDLE);
    assign rsp.valid   = out_valid_reg;
    assign rsp.data    = out_data_reg;
    assign rsp.status  = out_status_reg;
    assign rsp.is_last = out_last_reg;

    // slot offset for the shared adder
    always_comb
    begin
        offset = idx_reg;
        case (state_reg)
            S_EXEC:
            begin
                if (op_reg == OP_INS_FRONT)
                begin
                    offset = CW'(DEPTH - 1);
                end
                else if (op_reg == OP_INS_END)
                begin
                    offset = count_reg;
                end
            end
            S_DEL_RD:
            begin
                offset = idx_inc;
            end
            default:
            begin
                offset = idx_reg;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_fire)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (op_reg)
                    OP_DELETE:
                    begin
                        state_next = (empty || bad_pos) ? S_RESP : S_DEL_RD;
                    end
                    OP_DISPLAY:
                    begin
                        state_next = empty ? S_RESP : S_DISP_RD;
                    end
                    default:
                    begin
                        state_next = S_RESP;
                    end
                endcase
            end
            S_DEL_RD:
            begin
                state_next = (idx_inc < count_reg) ? S_DEL_WR : S_RESP;
            end
            S_DEL_WR:
            begin
                state_next = S_DEL_RD;
            end
            S_DISP_RD:
            begin
                state_next = S_DISP_LD;
            end
            S_DISP_LD:
            begin
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (rsp_fire)
                begin
                    if (op_reg == OP_DISPLAY && !out_last_reg)
                    begin
                        state_next = S_DISP_RD;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        head_next       = head_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        op_next         = op_reg;
        value_next      = value_reg;
        pos_next        = pos_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;
        store_req       = '{wr_en: 1'b0, addr: slot, wr_data: value_reg};

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_fire)
                begin
                    op_next    = cmd.opcode;
                    value_next = cmd.value;
                    pos_next   = cmd.position;
                end
            end
            S_EXEC:
            begin
                out_valid_next  = 1'b1;
                out_data_next   = '0;
                out_status_next = ST_OK;
                out_last_next   = 1'b1;
                case (op_reg)
                    OP_INS_FRONT:
                    begin
                        if (full)
                        begin
                            out_status_next = ST_FULL;
                        end
                        else
                        begin
                            store_req.wr_en = 1'b1;
                            head_next       = slot;
                            count_next      = count_reg + CW'(1);
                        end
                    end
                    OP_INS_END:
                    begin
                        if (full)
                        begin
                            out_status_next = ST_FULL;
                        end
                        else
                        begin
                            store_req.wr_en = 1'b1;
                            count_next      = count_reg + CW'(1);
                        end
                    end
                    OP_DELETE:
                    begin
                        if (empty)
                        begin
                            out_status_next = ST_EMPTY;
                        end
                        else if (bad_pos)
                        begin
                            out_status_next = ST_BADPOS;
                        end
                        else
                        begin
                            out_valid_next = 1'b0;
                            idx_next       = CW'(PW'(pos_reg) - PW'(1));
                        end
                    end
                    default:
                    begin
                        if (empty)
                        begin
                            out_status_next = ST_EMPTY;
                        end
                        else
                        begin
                            out_valid_next = 1'b0;
                            idx_next       = '0;
                        end
                    end
                endcase
            end
            S_DEL_RD:
            begin
                // fetch the follower; once none is left the gap is closed
                if (!(idx_inc < count_reg))
                begin
                    count_next      = count_reg - CW'(1);
                    out_valid_next  = 1'b1;
                    out_data_next   = '0;
                    out_status_next = ST_OK;
                    out_last_next   = 1'b1;
                end
            end
            S_DEL_WR:
            begin
                store_req.wr_en   = 1'b1;
                store_req.wr_data = rd_data;
                idx_next          = idx_inc;
            end
            S_DISP_RD:
            begin
                store_req.wr_en = 1'b0;
            end
            S_DISP_LD:
            begin
                out_valid_next  = 1'b1;
                out_data_next   = rd_data;
                out_status_next = ST_OK;
                out_last_next   = (idx_inc == count_reg);
                idx_next        = idx_inc;
            end
            S_RESP:
            begin
                if (rsp_fire)
                begin
                    out_valid_next = 1'b0;
                end
            end
            default:
            begin
                out_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        op_reg         <= op_next;
        value_reg      <= value_next;
        pos_reg        <= pos_next;
        out_data_reg   <= out_data_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
    end

endmodule

`default_nettype wire
